[sv/ssp_pkg.sv]
// Shared types and constants of the shortest path block.
package ssp_pkg;

    localparam int NODE_W    = 5;
    localparam int NCNT_W    = 6;
    localparam int MAX_NODES = 32;
    localparam int DIST_W    = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 6;

    localparam logic signed [DIST_W-1:0] DIST_MAX = 24'sh7FFFFF;
    localparam logic signed [DIST_W-1:0] DIST_MIN = 24'sh800000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_NODE = 2'd1;

    // Request kinds
    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_START = 1'b1
    } t_action;

    // Engine sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_EREAD,
        S_DREAD,
        S_CALC,
        S_UPD,
        S_OREAD,
        S_OSEND,
        S_ONEG,
        S_DONE
    } t_state;

    // Configuration as seen by the engine
    typedef struct packed {
        logic [NCNT_W-1:0] node_count;
        logic [NODE_W-1:0] source_node;
    } t_cfg;

endpackage

[sv/ssp_front.sv]
// Front end: accepts requests, classifies them and queues them for the engine.
module ssp_front #(
    parameter int WEIGHT_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_action,
    input  logic [ssp_pkg::NODE_W-1:0]      i_edge_source,
    input  logic [ssp_pkg::NODE_W-1:0]      i_edge_destination,
    input  logic signed [WEIGHT_BITS-1:0]   i_edge_weight,
    output logic                            o_req_valid,
    output ssp_pkg::t_action                o_req_action,
    output logic [ssp_pkg::NODE_W-1:0]      o_req_tail,
    output logic [ssp_pkg::NODE_W-1:0]      o_req_head,
    output logic signed [WEIGHT_BITS-1:0]   o_req_weight,
    input  logic                            i_req_pop
);
    import ssp_pkg::*;

    localparam int QW = 1 + 2 * NODE_W + WEIGHT_BITS;

    logic [QW-1:0] r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          w_push, w_pop;
    t_action       w_kind;
    logic [QW-1:0] w_head;

    // Classify the incoming request
    assign w_kind  = t_action'(i_action);
    assign o_stall = (r_cnt == 2'd2);
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = i_req_pop && o_req_valid;

    // Two-entry queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= {w_kind, i_edge_source, i_edge_destination, i_edge_weight};
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    assign w_head       = r_q[r_rp];
    assign o_req_valid  = (r_cnt != 2'd0);
    assign o_req_action = t_action'(w_head[QW-1]);
    assign o_req_tail   = w_head[QW-2 -: NODE_W];
    assign o_req_head   = w_head[QW-2-NODE_W -: NODE_W];
    assign o_req_weight = w_head[WEIGHT_BITS-1:0];

endmodule

[sv/ssp_engine.sv]
// Back end: edge store, node tables and the relaxation sequencer.
module ssp_engine #(
    parameter int MAX_EDGES   = 256,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ssp_pkg::t_cfg                   i_cfg,
    input  logic                            i_req_valid,
    input  ssp_pkg::t_action                i_req_action,
    input  logic [ssp_pkg::NODE_W-1:0]      i_req_tail,
    input  logic [ssp_pkg::NODE_W-1:0]      i_req_head,
    input  logic signed [WEIGHT_BITS-1:0]   i_req_weight,
    output logic                            o_req_pop,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [ssp_pkg::NODE_W-1:0]      o_node,
    output logic                            o_reachable,
    output logic signed [ssp_pkg::DIST_W-1:0] o_distance,
    output logic [ssp_pkg::NODE_W-1:0]      o_predecessor,
    output logic                            o_has_predecessor,
    output logic                            o_negative_cycle,
    output logic                            o_last
);
    import ssp_pkg::*;

    localparam int EAW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW   = $clog2(MAX_EDGES + 1);
    localparam int EW    = 2 * NODE_W + WEIGHT_BITS;
    localparam int SUM_W = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;

    t_state r_state, n_state;

    // Storage
    logic [EW-1:0]              r_edge_mem [MAX_EDGES];
    logic [EW-1:0]              r_edge_q;
    logic signed [DIST_W-1:0]   r_dist_mem [MAX_NODES];
    logic signed [DIST_W-1:0]   r_dist_a, r_dist_b;
    logic [MAX_NODES-1:0]       r_reached, r_hasp;
    logic [NODE_W-1:0]          r_parent [MAX_NODES];

    // Control
    logic [ECW-1:0]             r_edge_total, r_e;
    logic [NCNT_W-1:0]          r_n, r_pass;
    logic [NODE_W-1:0]          r_src, r_i;
    logic                       r_check, r_neg;
    logic signed [DIST_W-1:0]   r_sum;
    logic                       r_under, r_active, r_scan;

    // Combinational helpers
    logic [NODE_W-1:0]          w_tail, w_head;
    logic signed [WEIGHT_BITS-1:0] w_weight;
    logic signed [SUM_W-1:0]    w_sum_full;
    logic                       w_relax, w_hit, w_last_edge, w_out_free;
    logic                       w_edge_rd, w_dist_rd, w_out_load, w_start_pop;
    logic                       w_dist_we;
    logic [NODE_W-1:0]          w_dist_waddr, w_rd_addr_a;
    logic signed [DIST_W-1:0]   w_dist_wdata;
    logic [NCNT_W-1:0]          w_n_clamp;
    logic                       w_isrc, w_hp, w_r;

    assign w_tail   = r_edge_q[EW-1 -: NODE_W];
    assign w_head   = r_edge_q[EW-1-NODE_W -: NODE_W];
    assign w_weight = r_edge_q[WEIGHT_BITS-1:0];

    assign w_sum_full  = SUM_W'(r_dist_a) + SUM_W'(w_weight);
    assign w_relax     = r_active && (!r_reached[w_head] || (r_sum < r_dist_b));
    assign w_hit       = r_scan || (r_active && (r_under || w_relax));
    assign w_last_edge = ((r_e + ECW'(1)) == r_edge_total);
    assign w_out_free  = !o_valid || !i_stall;
    assign w_start_pop = o_req_pop && (i_req_action == ACT_START);

    // Node count clamp to 1..MAX_NODES
    always_comb begin
        if (i_cfg.node_count == '0) begin
            w_n_clamp = NCNT_W'(1);
        end else if (i_cfg.node_count > NCNT_W'(MAX_NODES)) begin
            w_n_clamp = NCNT_W'(MAX_NODES);
        end else begin
            w_n_clamp = i_cfg.node_count;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_req_valid && i_req_action == ACT_START) n_state = S_INIT;
            S_INIT:  n_state = (r_edge_total == '0) ? S_OREAD : S_EREAD;
            S_EREAD: n_state = S_DREAD;
            S_DREAD: n_state = S_CALC;
            S_CALC:  n_state = S_UPD;
            S_UPD: begin
                if (r_check && w_last_edge) begin
                    n_state = (r_neg || w_hit) ? S_ONEG : S_OREAD;
                end else begin
                    n_state = S_EREAD;
                end
            end
            S_OREAD: n_state = S_OSEND;
            S_OSEND: begin
                if (w_out_free) begin
                    n_state = ({1'b0, r_i} == r_n - NCNT_W'(1)) ? S_DONE : S_OREAD;
                end
            end
            S_ONEG:  if (w_out_free) n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State decoded strobes
    always_comb begin
        o_req_pop  = (r_state == S_IDLE) && i_req_valid;
        w_edge_rd  = (r_state == S_EREAD);
        w_dist_rd  = (r_state == S_DREAD) || (r_state == S_OREAD);
        w_out_load = ((r_state == S_OSEND) || (r_state == S_ONEG)) && w_out_free;
        w_dist_we  = 1'b0;
        w_dist_waddr = w_head;
        w_dist_wdata = r_sum;
        if (r_state == S_INIT) begin
            w_dist_we    = ({1'b0, r_src} < r_n);
            w_dist_waddr = r_src;
            w_dist_wdata = '0;
        end else if (r_state == S_UPD) begin
            w_dist_we    = !r_check && w_relax;
        end
        w_rd_addr_a = (r_state == S_OREAD) ? r_i : w_tail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Edge store
    always_ff @(posedge i_clk) begin
        if (o_req_pop && i_req_action == ACT_LOAD && r_edge_total < ECW'(MAX_EDGES)) begin
            r_edge_mem[r_edge_total[EAW-1:0]] <= {i_req_tail, i_req_head, i_req_weight};
        end
        if (w_edge_rd) r_edge_q <= r_edge_mem[r_e[EAW-1:0]];
    end

    // Distance table, one write and two registered reads
    always_ff @(posedge i_clk) begin
        if (w_dist_we) r_dist_mem[w_dist_waddr] <= w_dist_wdata;
        if (w_dist_rd) begin
            r_dist_a <= r_dist_mem[w_rd_addr_a];
            r_dist_b <= r_dist_mem[w_head];
        end
    end

    // Candidate sum with saturation
    always_ff @(posedge i_clk) begin
        if (r_state == S_CALC) begin
            if (w_sum_full < SUM_W'(DIST_MIN)) begin
                r_sum   <= DIST_MIN;
                r_under <= 1'b1;
            end else if (w_sum_full > SUM_W'(DIST_MAX)) begin
                r_sum   <= DIST_MAX;
                r_under <= 1'b0;
            end else begin
                r_sum   <= w_sum_full[DIST_W-1:0];
                r_under <= 1'b0;
            end
            r_active <= ({1'b0, w_tail} < r_n) && ({1'b0, w_head} < r_n)
                        && r_reached[w_tail];
            r_scan   <= ({1'b0, w_tail} < r_n) && r_reached[w_tail]
                        && (r_dist_a == DIST_MIN);
        end
    end

    // Parent table
    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD && !r_check && w_relax) r_parent[w_head] <= w_tail;
    end

    // Sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_total <= '0;
            r_reached    <= '0;
            r_hasp       <= '0;
            r_e          <= '0;
            r_n          <= NCNT_W'(MAX_NODES);
            r_pass       <= '0;
            r_src        <= '0;
            r_i          <= '0;
            r_check      <= 1'b0;
            r_neg        <= 1'b0;
        end else begin
            if (o_req_pop && i_req_action == ACT_LOAD && r_edge_total < ECW'(MAX_EDGES)) begin
                r_edge_total <= r_edge_total + ECW'(1);
            end
            if (w_start_pop) begin
                r_n   <= w_n_clamp;
                r_src <= i_cfg.source_node;
            end
            unique case (r_state)
                S_INIT: begin
                    // only the source starts out reached
                    r_reached <= ({1'b0, r_src} < r_n) ? (MAX_NODES'(1) << r_src) : '0;
                    r_hasp  <= '0;
                    r_e     <= '0;
                    r_pass  <= NCNT_W'(1);
                    r_check <= (r_n == NCNT_W'(1));
                    r_neg   <= 1'b0;
                    r_i     <= '0;
                end
                S_UPD: begin
                    if (!r_check && w_relax) begin
                        r_reached[w_head] <= 1'b1;
                        r_hasp[w_head]    <= 1'b1;
                    end
                    if (r_check) r_neg <= r_neg || w_hit;
                    if (w_last_edge) begin
                        r_e <= '0;
                        if (!r_check) begin
                            if (r_pass + NCNT_W'(1) < r_n) r_pass <= r_pass + NCNT_W'(1);
                            else                          r_check <= 1'b1;
                        end
                    end else begin
                        r_e <= r_e + ECW'(1);
                    end
                end
                S_OSEND: if (w_out_free) r_i <= r_i + NODE_W'(1);
                S_DONE:  r_edge_total <= '0;
                default: ;
            endcase
        end
    end

    // Result fields of one node
    assign w_r    = r_reached[r_i];
    assign w_isrc = (r_i == r_src);
    assign w_hp   = w_r && !w_isrc && r_hasp[r_i];

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_out_load) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            if (r_state == S_ONEG) begin
                o_node            <= '0;
                o_reachable       <= 1'b0;
                o_distance        <= '0;
                o_predecessor     <= '0;
                o_has_predecessor <= 1'b0;
                o_negative_cycle  <= 1'b1;
                o_last            <= 1'b1;
            end else begin
                o_node            <= r_i;
                o_reachable       <= w_r;
                o_distance        <= (w_r && !w_isrc) ? r_dist_a : '0;
                o_predecessor     <= w_hp ? r_parent[r_i] : '0;
                o_has_predecessor <= w_hp;
                o_negative_cycle  <= 1'b0;
                o_last            <= ({1'b0, r_i} == r_n - NCNT_W'(1));
            end
        end
    end

    // Checks
    a_edge_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edge_total <= ECW'(MAX_EDGES))
        else $error("edge count beyond store depth");

    a_init_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INIT |=> $onehot0(r_reached))
        else $error("more than one node reached after init");

    a_start_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start_pop |=> r_state == S_INIT)
        else $error("start request did not enter init");

    a_neg_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_neg) |-> $past(r_check))
        else $error("negative cycle flagged outside check pass");

    a_done_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |=> r_edge_total == '0)
        else $error("edge store not emptied after a run");

endmodule

[sv/single_source_shortest_paths.sv]
// Top level: Bellman-Ford shortest paths over a loaded edge list.
//
//  channel  direction  handshake                 contents
//  input    in         i_valid / o_stall         action, edge tail, head, weight
//  result   out        o_valid / i_stall         node, reach, distance, parent, flags
//  config   in         i_cfg_valid / o_cfg_ready register index, write data
//
// Edge loads go into a two-entry queue and retire one per cycle while the engine is idle.
// A start runs node_count passes (the last checks for negative cycles), each edge taking
// edge read, distance read, add and update in the single relaxation unit, then sends each
// node's result or one negative cycle flag. Reset is synchronous; the edge store needs no
// clearing pass. A stalled result holds the output register and the sequencer waits on it.
module single_source_shortest_paths #(
    parameter int MAX_EDGES   = 256,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_action,
    input  logic [ssp_pkg::NODE_W-1:0]         i_edge_source,
    input  logic [ssp_pkg::NODE_W-1:0]         i_edge_destination,
    input  logic signed [WEIGHT_BITS-1:0]      i_edge_weight,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [ssp_pkg::NODE_W-1:0]         o_node,
    output logic                               o_reachable,
    output logic signed [ssp_pkg::DIST_W-1:0]  o_distance,
    output logic [ssp_pkg::NODE_W-1:0]         o_predecessor,
    output logic                               o_has_predecessor,
    output logic                               o_negative_cycle,
    output logic                               o_last,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ssp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ssp_pkg::CFG_DAT_W-1:0]      i_cfg_data
);
    import ssp_pkg::*;

    t_cfg                       r_cfg;
    logic                       w_req_valid, w_req_pop;
    t_action                    w_req_action;
    logic [NODE_W-1:0]          w_req_tail, w_req_head;
    logic signed [WEIGHT_BITS-1:0] w_req_weight;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node_count  <= NCNT_W'(MAX_NODES);
            r_cfg.source_node <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_NODE_COUNT:  r_cfg.node_count  <= i_cfg_data[NCNT_W-1:0];
                CFG_SOURCE_NODE: r_cfg.source_node <= i_cfg_data[NODE_W-1:0];
                default: ;
            endcase
        end
    end

    ssp_front #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_action           (i_action),
        .i_edge_source      (i_edge_source),
        .i_edge_destination (i_edge_destination),
        .i_edge_weight      (i_edge_weight),
        .o_req_valid        (w_req_valid),
        .o_req_action       (w_req_action),
        .o_req_tail         (w_req_tail),
        .o_req_head         (w_req_head),
        .o_req_weight       (w_req_weight),
        .i_req_pop          (w_req_pop)
    );

    ssp_engine #(
        .MAX_EDGES   (MAX_EDGES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_engine (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_req_valid       (w_req_valid),
        .i_req_action      (w_req_action),
        .i_req_tail        (w_req_tail),
        .i_req_head        (w_req_head),
        .i_req_weight      (w_req_weight),
        .o_req_pop         (w_req_pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_node            (o_node),
        .o_reachable       (o_reachable),
        .o_distance        (o_distance),
        .o_predecessor     (o_predecessor),
        .o_has_predecessor (o_has_predecessor),
        .o_negative_cycle  (o_negative_cycle),
        .o_last            (o_last)
    );

endmodule
